// File: rtl/tpr_pkg.sv
// Package for the trapezoidal PWM ramp profile block: widths, register
// indexes, reset values, phase codes and the microcode ROM of the sequencer.
// No dependencies.
`default_nettype none

package tpr_pkg;

    localparam int TPR_COUNT_WIDTH = 16;

    localparam int MAXD_W      = 7;
    localparam int PER_W       = 16;
    localparam int LEN_W       = 16;
    localparam int PCT_SCALE   = 100;
    localparam int PCT_PROD_W  = MAXD_W + PER_W;   // duty * period
    localparam int DIVISOR_W   = LEN_W + MAXD_W;   // length * 100 fits here
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_DUTY   = 3'd0,
        REG_PERIOD     = 3'd1,
        REG_UP_START   = 3'd2,
        REG_UP_TICKS   = 3'd3,
        REG_HOLD_TICKS = 3'd4,
        REG_DOWN_TICKS = 3'd5
    } cfg_reg_t;

    localparam logic [MAXD_W-1:0] RST_MAX_DUTY   = 7'd100;
    localparam logic [PER_W-1:0]  RST_PERIOD     = 16'd65535;
    localparam logic [LEN_W-1:0]  RST_UP_START   = 16'd1000;
    localparam logic [LEN_W-1:0]  RST_UP_TICKS   = 16'd2000;
    localparam logic [LEN_W-1:0]  RST_HOLD_TICKS = 16'd1000;
    localparam logic [LEN_W-1:0]  RST_DOWN_TICKS = 16'd1000;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_UP   = 2'd1,
        PH_HOLD = 2'd2,
        PH_DOWN = 2'd3
    } phase_t;

    // Divider operand selection
    typedef enum logic [1:0] {
        DS_DUTY = 2'd0,   // count*max / ramp_up_ticks
        DS_PCT  = 2'd1,   // duty*period / 100
        DS_DOWN = 2'd2    // count*max*period / (ramp_down_ticks*100)
    } dsel_t;

    typedef struct packed {
        logic  start;
        dsel_t sel;
    } div_cmd_t;

    typedef enum logic [4:0] {
        U_NOP,
        U_UP_ENTER,
        U_CNT_INC,
        U_CNT_DEC,
        U_MUL_CM,
        U_MUL_DP,
        U_MUL_P,
        U_DIV_DUTY,
        U_DIV_PCT,
        U_DIV_DOWN,
        U_SET_DUTY,
        U_DUTY_MAX,
        U_CAP_CMP,
        U_CMP_ZERO,
        U_UP_END,
        U_HOLD_ENTER,
        U_HOLD_END,
        U_DOWN_ENTER,
        U_DOWN_END,
        U_IDLE_STEP,
        U_LEAVE,
        U_EMIT
    } uop_t;

    typedef enum logic [3:0] {
        C_NEXT,
        C_ALWAYS,
        C_IDLE,
        C_STOP,
        C_HOLD,
        C_DOWN,
        C_ENTERED,
        C_UPZERO,
        C_DNZERO,
        C_DIVBUSY,
        C_OUTFULL
    } ucond_t;

    localparam int UADDR_W = 6;
    typedef logic [UADDR_W-1:0] uaddr_t;

    typedef struct packed {
        uop_t   op;
        ucond_t cond;
        uaddr_t target;
        logic   last;
    } uword_t;

    localparam uaddr_t A_START      = 6'd0;
    localparam uaddr_t A_UP_COUNT   = 6'd6;
    localparam uaddr_t A_UP_DWAIT   = 6'd10;
    localparam uaddr_t A_UP_DUTYMAX = 6'd12;
    localparam uaddr_t A_UP_SCALE   = 6'd13;
    localparam uaddr_t A_UP_PWAIT   = 6'd15;
    localparam uaddr_t A_HOLD       = 6'd18;
    localparam uaddr_t A_HOLD_PWAIT = 6'd22;
    localparam uaddr_t A_HOLD_COUNT = 6'd24;
    localparam uaddr_t A_DOWN       = 6'd26;
    localparam uaddr_t A_DOWN_COUNT = 6'd28;
    localparam uaddr_t A_DOWN_DWAIT = 6'd33;
    localparam uaddr_t A_DOWN_ZERO  = 6'd35;
    localparam uaddr_t A_DOWN_END   = 6'd36;
    localparam uaddr_t A_IDLE       = 6'd37;
    localparam uaddr_t A_STOP       = 6'd38;
    localparam uaddr_t A_EMIT       = 6'd39;

    function automatic uword_t uw(input uop_t op, input ucond_t c, input uaddr_t t,
                                  input logic l);
        uword_t w;
        w.op     = op;
        w.cond   = c;
        w.target = t;
        w.last   = l;
        return w;
    endfunction

    // Per-tick program. A step runs its op, then jumps when its condition holds.
    function automatic uword_t ucode(input uaddr_t a);
        uword_t w;
        w = uw(U_EMIT, C_OUTFULL, A_EMIT, 1'b1);
        unique case (a)
            // dispatch
            6'd0:  w = uw(U_NOP,        C_IDLE,    A_IDLE,       1'b0);
            6'd1:  w = uw(U_NOP,        C_STOP,    A_STOP,       1'b0);
            6'd2:  w = uw(U_NOP,        C_HOLD,    A_HOLD,       1'b0);
            6'd3:  w = uw(U_NOP,        C_DOWN,    A_DOWN,       1'b0);
            // ramp up
            6'd4:  w = uw(U_NOP,        C_ENTERED, A_UP_COUNT,   1'b0);
            6'd5:  w = uw(U_UP_ENTER,   C_NEXT,    A_START,      1'b0);
            6'd6:  w = uw(U_CNT_INC,    C_NEXT,    A_START,      1'b0);
            6'd7:  w = uw(U_NOP,        C_UPZERO,  A_UP_DUTYMAX, 1'b0);
            6'd8:  w = uw(U_MUL_CM,     C_NEXT,    A_START,      1'b0);
            6'd9:  w = uw(U_DIV_DUTY,   C_NEXT,    A_START,      1'b0);
            6'd10: w = uw(U_NOP,        C_DIVBUSY, A_UP_DWAIT,   1'b0);
            6'd11: w = uw(U_SET_DUTY,   C_ALWAYS,  A_UP_SCALE,   1'b0);
            6'd12: w = uw(U_DUTY_MAX,   C_NEXT,    A_START,      1'b0);
            6'd13: w = uw(U_MUL_DP,     C_NEXT,    A_START,      1'b0);
            6'd14: w = uw(U_DIV_PCT,    C_NEXT,    A_START,      1'b0);
            6'd15: w = uw(U_NOP,        C_DIVBUSY, A_UP_PWAIT,   1'b0);
            6'd16: w = uw(U_CAP_CMP,    C_NEXT,    A_START,      1'b0);
            6'd17: w = uw(U_UP_END,     C_ALWAYS,  A_EMIT,       1'b0);
            // hold
            6'd18: w = uw(U_NOP,        C_ENTERED, A_HOLD_COUNT, 1'b0);
            6'd19: w = uw(U_HOLD_ENTER, C_NEXT,    A_START,      1'b0);
            6'd20: w = uw(U_MUL_DP,     C_NEXT,    A_START,      1'b0);
            6'd21: w = uw(U_DIV_PCT,    C_NEXT,    A_START,      1'b0);
            6'd22: w = uw(U_NOP,        C_DIVBUSY, A_HOLD_PWAIT, 1'b0);
            6'd23: w = uw(U_CAP_CMP,    C_NEXT,    A_START,      1'b0);
            6'd24: w = uw(U_CNT_INC,    C_NEXT,    A_START,      1'b0);
            6'd25: w = uw(U_HOLD_END,   C_ALWAYS,  A_EMIT,       1'b0);
            // ramp down
            6'd26: w = uw(U_NOP,        C_ENTERED, A_DOWN_COUNT, 1'b0);
            6'd27: w = uw(U_DOWN_ENTER, C_NEXT,    A_START,      1'b0);
            6'd28: w = uw(U_CNT_DEC,    C_NEXT,    A_START,      1'b0);
            6'd29: w = uw(U_NOP,        C_DNZERO,  A_DOWN_ZERO,  1'b0);
            6'd30: w = uw(U_MUL_CM,     C_NEXT,    A_START,      1'b0);
            6'd31: w = uw(U_MUL_P,      C_NEXT,    A_START,      1'b0);
            6'd32: w = uw(U_DIV_DOWN,   C_NEXT,    A_START,      1'b0);
            6'd33: w = uw(U_NOP,        C_DIVBUSY, A_DOWN_DWAIT, 1'b0);
            6'd34: w = uw(U_CAP_CMP,    C_ALWAYS,  A_DOWN_END,   1'b0);
            6'd35: w = uw(U_CMP_ZERO,   C_NEXT,    A_START,      1'b0);
            6'd36: w = uw(U_DOWN_END,   C_ALWAYS,  A_EMIT,       1'b0);
            // idle, stop, emit
            6'd37: w = uw(U_IDLE_STEP,  C_ALWAYS,  A_EMIT,       1'b0);
            6'd38: w = uw(U_LEAVE,      C_NEXT,    A_START,      1'b0);
            6'd39: w = uw(U_EMIT,       C_OUTFULL, A_EMIT,       1'b1);
            default: w = uw(U_EMIT,     C_OUTFULL, A_EMIT,       1'b1);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// File: rtl/tpr_if.sv
// Valid/ready channel interfaces of the ramp profile block: the tick channel
// and the result channel. No dependencies.
`default_nettype none

interface tpr_in_if;
    logic valid;
    logic ready;
    logic start_request;
    logic stop_request;

    modport source (output valid, output start_request, output stop_request,
                    input ready);
    modport sink   (input valid, input start_request, input stop_request,
                    output ready);
endinterface

interface tpr_out_if;
    logic        valid;
    logic        ready;
    logic        pwm_enable;
    logic [15:0] compare_value;
    logic [1:0]  phase;

    modport source (output valid, output pwm_enable, output compare_value,
                    output phase, input ready);
    modport sink   (input valid, input pwm_enable, input compare_value,
                    input phase, output ready);
endinterface

`default_nettype wire

// File: rtl/tpr_div.sv
// Serial restoring divider, one quotient bit per cycle, with operand
// alignment per divide kind; the divide by the percent scale is a one-step
// reciprocal multiply. Depends on tpr_pkg.
`default_nettype none

module tpr_div
    import tpr_pkg::*;
#(
    parameter int COUNT_WIDTH = TPR_COUNT_WIDTH,
    localparam int PW3 = COUNT_WIDTH + MAXD_W + PER_W
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  div_cmd_t         cmd,
    input  logic [PW3-1:0]   dividend,
    input  logic [LEN_W-1:0] up_ticks,
    input  logic [LEN_W-1:0] down_ticks,
    output logic             busy,
    output logic [PW3-1:0]   quotient
);

    localparam int PW1 = COUNT_WIDTH + MAXD_W;
    localparam int IW  = $clog2(PW3 + 1);
    // floor(x / 100) = (x * ceil(2^30 / 100)) >> 30, exact for any 23-bit x
    localparam int RCP_SH    = 30;
    localparam int RCP_W     = 24;
    localparam int PCT_MUL_W = PCT_PROD_W + RCP_W;
    localparam logic [RCP_W-1:0] RCP_MUL =
        RCP_W'(((64'd1 << RCP_SH) + 64'(PCT_SCALE) - 64'd1) / 64'(PCT_SCALE));

    logic [PW3-1:0]       quo_reg, quo_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [DIVISOR_W-1:0] dvsr_reg, dvsr_next;
    logic [IW-1:0]        iter_reg, iter_next;
    logic [DIVISOR_W:0]   trial;
    logic [PCT_MUL_W-1:0] pct_prod;

    assign trial    = {rem_reg, quo_reg[PW3-1]};
    assign pct_prod = PCT_MUL_W'(dividend[PCT_PROD_W-1:0]) * PCT_MUL_W'(RCP_MUL);

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvsr_next = dvsr_reg;
        iter_next = iter_reg;
        if (cmd.start)
        begin
            rem_next = '0;
            // dividend goes to the top so that only its own bits are walked
            unique case (cmd.sel)
                DS_DUTY:
                begin
                    quo_next  = {dividend[PW1-1:0], {(PW3-PW1){1'b0}}};
                    dvsr_next = DIVISOR_W'(up_ticks);
                    iter_next = IW'(PW1);
                end
                DS_PCT:
                begin
                    // done in this step, no iterations
                    quo_next  = PW3'(pct_prod[PCT_MUL_W-1:RCP_SH]);
                    iter_next = '0;
                end
                DS_DOWN:
                begin
                    quo_next  = dividend;
                    dvsr_next = DIVISOR_W'(down_ticks) * DIVISOR_W'(PCT_SCALE);
                    iter_next = IW'(PW3);
                end
                default:
                begin
                    iter_next = '0;
                end
            endcase
        end
        else if (iter_reg != '0)
        begin
            iter_next = iter_reg - 1'b1;
            if (trial >= {1'b0, dvsr_reg})
            begin
                rem_next = DIVISOR_W'(trial - {1'b0, dvsr_reg});
                quo_next = {quo_reg[PW3-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DIVISOR_W-1:0];
                quo_next = {quo_reg[PW3-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iter_reg <= '0;
        end
        else
        begin
            iter_reg <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
    end

    assign busy     = (iter_reg != '0);
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// File: rtl/trapezoidal_pwm_ramp_profile.sv
// Top level of the trapezoidal PWM ramp profile: configuration registers,
// microcoded sequencer, datapath and result register.
// Depends on tpr_pkg, tpr_if (tpr_in_if, tpr_out_if) and tpr_div.
//
//  channel  dir  fields                                   handshake
//  tick     in   start_request, stop_request              valid/ready
//  result   out  pwm_enable, compare_value[15:0], phase   valid/ready
//  cfg      in   cfg_index[2:0], cfg_data[15:0]           cfg_write strobe
//
// One item is taken at a time: a new tick is not accepted until the sequencer
// has finished the last one. In the ramps the serial divides, one quotient bit
// per cycle, take most of the work of a tick.
// Reset clears the control state and loads the register defaults; no clearing pass.
// A result waits in its own register; the next tick is accepted meanwhile and
// only its final step waits for the result register to drain.
`default_nettype none

module trapezoidal_pwm_ramp_profile
    import tpr_pkg::*;
#(
    parameter int COUNT_WIDTH = TPR_COUNT_WIDTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    tpr_in_if.sink                tick,
    tpr_out_if.source             result,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CW  = COUNT_WIDTH;
    localparam int PW1 = CW + MAXD_W;
    localparam int PW3 = PW1 + PER_W;
    localparam int XW  = (CW > LEN_W) ? CW : LEN_W;

    // configuration
    logic [MAXD_W-1:0] max_duty_reg;
    logic [PER_W-1:0]  period_reg;
    logic [LEN_W-1:0]  up_start_reg;
    logic [LEN_W-1:0]  up_ticks_reg;
    logic [LEN_W-1:0]  hold_ticks_reg;
    logic [LEN_W-1:0]  down_ticks_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_duty_reg   <= RST_MAX_DUTY;
            period_reg     <= RST_PERIOD;
            up_start_reg   <= RST_UP_START;
            up_ticks_reg   <= RST_UP_TICKS;
            hold_ticks_reg <= RST_HOLD_TICKS;
            down_ticks_reg <= RST_DOWN_TICKS;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_MAX_DUTY:   max_duty_reg   <= cfg_data[MAXD_W-1:0];
                REG_PERIOD:     period_reg     <= cfg_data[PER_W-1:0];
                REG_UP_START:   up_start_reg   <= cfg_data[LEN_W-1:0];
                REG_UP_TICKS:   up_ticks_reg   <= cfg_data[LEN_W-1:0];
                REG_HOLD_TICKS: hold_ticks_reg <= cfg_data[LEN_W-1:0];
                REG_DOWN_TICKS: down_ticks_reg <= cfg_data[LEN_W-1:0];
                default:        ;
            endcase
        end
    end

    // sequencer and profile state
    logic        seq_busy_reg, seq_busy_next;
    uaddr_t      upc_reg, upc_next;
    uword_t      uword;
    logic        take_jump;

    phase_t      phase_reg, phase_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic        entered_reg, entered_next;
    logic        running_reg, running_next;
    logic        start_pend_reg, start_pend_next;
    logic        stop_pend_reg, stop_pend_next;
    logic [PER_W-1:0] cmp_reg, cmp_next;

    logic [PW3-1:0]    prod_reg, prod_next;
    logic [MAXD_W-1:0] duty_reg, duty_next;

    logic              out_valid_reg, out_valid_next;
    logic              out_pwm_reg, out_pwm_next;
    logic [PER_W-1:0]  out_cmp_reg, out_cmp_next;
    logic [1:0]        out_phase_reg, out_phase_next;

    logic              accept;
    logic              out_hold;
    div_cmd_t          div_cmd;
    logic              div_busy;
    logic [PW3-1:0]    quotient;

    logic [PW1-1:0]        mul_cm;
    logic [PW3-1:0]        mul_p;
    logic [PCT_PROD_W-1:0] mul_dp;

    assign tick.ready = !seq_busy_reg;
    assign accept     = tick.valid && !seq_busy_reg;
    assign out_hold   = out_valid_reg && !result.ready;
    assign uword      = ucode(upc_reg);

    assign mul_cm = PW1'(cnt_reg) * PW1'(max_duty_reg);
    assign mul_p  = PW3'(prod_reg[PW1-1:0]) * PW3'(period_reg);
    assign mul_dp = PCT_PROD_W'(duty_reg) * PCT_PROD_W'(period_reg);

    always_comb
    begin
        unique case (uword.cond)
            C_NEXT:    take_jump = 1'b0;
            C_ALWAYS:  take_jump = 1'b1;
            C_IDLE:    take_jump = (phase_reg == PH_IDLE);
            C_STOP:    take_jump = stop_pend_reg;
            C_HOLD:    take_jump = (phase_reg == PH_HOLD);
            C_DOWN:    take_jump = (phase_reg == PH_DOWN);
            C_ENTERED: take_jump = entered_reg;
            C_UPZERO:  take_jump = (up_ticks_reg == '0);
            C_DNZERO:  take_jump = (down_ticks_reg == '0);
            C_DIVBUSY: take_jump = div_busy;
            C_OUTFULL: take_jump = out_hold;
            default:   take_jump = 1'b0;
        endcase
    end

    always_comb
    begin
        seq_busy_next = seq_busy_reg;
        upc_next      = upc_reg;
        if (!seq_busy_reg)
        begin
            if (accept)
            begin
                seq_busy_next = 1'b1;
                upc_next      = A_START;
            end
        end
        else if (take_jump)
        begin
            upc_next = uword.target;
        end
        else if (uword.last)
        begin
            seq_busy_next = 1'b0;
            upc_next      = A_START;
        end
        else
        begin
            upc_next = UADDR_W'(upc_reg + 1'b1);
        end
    end

    always_comb
    begin
        phase_next      = phase_reg;
        cnt_next        = cnt_reg;
        entered_next    = entered_reg;
        running_next    = running_reg;
        start_pend_next = start_pend_reg;
        stop_pend_next  = stop_pend_reg;
        cmp_next        = cmp_reg;
        prod_next       = prod_reg;
        duty_next       = duty_reg;
        out_valid_next  = out_valid_reg;
        out_pwm_next    = out_pwm_reg;
        out_cmp_next    = out_cmp_reg;
        out_phase_next  = out_phase_reg;
        div_cmd.start   = 1'b0;
        div_cmd.sel     = DS_DUTY;

        if (result.valid && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (accept)
        begin
            start_pend_next = start_pend_reg | tick.start_request;
            stop_pend_next  = stop_pend_reg | tick.stop_request;
        end

        if (seq_busy_reg)
        begin
            case (uword.op)
                U_UP_ENTER:
                begin
                    entered_next = 1'b1;
                    cnt_next     = CW'(up_start_reg);
                    cmp_next     = '0;
                    running_next = 1'b1;
                end
                U_CNT_INC:
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                U_CNT_DEC:
                begin
                    if (cnt_reg != '0)
                    begin
                        cnt_next = cnt_reg - 1'b1;
                    end
                end
                U_MUL_CM:   prod_next = PW3'(mul_cm);
                U_MUL_P:    prod_next = mul_p;
                U_MUL_DP:   prod_next = PW3'(mul_dp);
                U_DIV_DUTY:
                begin
                    div_cmd.start = 1'b1;
                    div_cmd.sel   = DS_DUTY;
                end
                U_DIV_PCT:
                begin
                    div_cmd.start = 1'b1;
                    div_cmd.sel   = DS_PCT;
                end
                U_DIV_DOWN:
                begin
                    div_cmd.start = 1'b1;
                    div_cmd.sel   = DS_DOWN;
                end
                U_SET_DUTY:
                begin
                    duty_next = (quotient > PW3'(max_duty_reg)) ? max_duty_reg
                                                                : quotient[MAXD_W-1:0];
                end
                U_DUTY_MAX: duty_next = max_duty_reg;
                U_CAP_CMP:
                begin
                    cmp_next = (quotient > PW3'(period_reg)) ? period_reg
                                                             : quotient[PER_W-1:0];
                end
                U_CMP_ZERO: cmp_next = '0;
                U_UP_END:
                begin
                    if (XW'(cnt_reg) >= XW'(up_ticks_reg))
                    begin
                        entered_next = 1'b0;
                        phase_next   = PH_HOLD;
                    end
                end
                U_HOLD_ENTER:
                begin
                    entered_next = 1'b1;
                    cnt_next     = '0;
                    duty_next    = max_duty_reg;
                end
                U_HOLD_END:
                begin
                    if (XW'(cnt_reg) >= XW'(hold_ticks_reg))
                    begin
                        entered_next = 1'b0;
                        phase_next   = PH_DOWN;
                    end
                end
                U_DOWN_ENTER:
                begin
                    entered_next = 1'b1;
                    cnt_next     = CW'(down_ticks_reg);
                end
                U_DOWN_END:
                begin
                    if (cnt_reg == '0)
                    begin
                        entered_next = 1'b0;
                        phase_next   = PH_IDLE;
                    end
                end
                U_IDLE_STEP:
                begin
                    // a stop seen in idle is dropped; start wins
                    stop_pend_next = 1'b0;
                    running_next   = 1'b0;
                    if (start_pend_reg)
                    begin
                        start_pend_next = 1'b0;
                        entered_next    = 1'b0;
                        phase_next      = PH_UP;
                    end
                end
                U_LEAVE:
                begin
                    stop_pend_next = 1'b0;
                    entered_next   = 1'b0;
                    running_next   = 1'b0;
                    phase_next     = PH_IDLE;
                end
                U_EMIT:
                begin
                    if (!out_hold)
                    begin
                        out_valid_next = 1'b1;
                        out_pwm_next   = running_reg;
                        out_cmp_next   = cmp_reg;
                        out_phase_next = phase_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_busy_reg   <= 1'b0;
            upc_reg        <= A_START;
            phase_reg      <= PH_IDLE;
            cnt_reg        <= '0;
            entered_reg    <= 1'b0;
            running_reg    <= 1'b0;
            start_pend_reg <= 1'b0;
            stop_pend_reg  <= 1'b0;
            cmp_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            seq_busy_reg   <= seq_busy_next;
            upc_reg        <= upc_next;
            phase_reg      <= phase_next;
            cnt_reg        <= cnt_next;
            entered_reg    <= entered_next;
            running_reg    <= running_next;
            start_pend_reg <= start_pend_next;
            stop_pend_reg  <= stop_pend_next;
            cmp_reg        <= cmp_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg      <= prod_next;
        duty_reg      <= duty_next;
        out_pwm_reg   <= out_pwm_next;
        out_cmp_reg   <= out_cmp_next;
        out_phase_reg <= out_phase_next;
    end

    tpr_div #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (div_cmd),
        .dividend   (prod_reg),
        .up_ticks   (up_ticks_reg),
        .down_ticks (down_ticks_reg),
        .busy       (div_busy),
        .quotient   (quotient)
    );

    assign result.valid         = out_valid_reg;
    assign result.pwm_enable    = out_pwm_reg;
    assign result.compare_value = out_cmp_reg;
    assign result.phase         = out_phase_reg;

    // a new divide is never issued over one still running
    a_div_start_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_cmd.start |-> !div_busy)
        else $error("divider started while busy");

    // the result register is never overwritten while it is still held
    a_emit_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_busy_reg && uword.op == U_EMIT && out_hold) |=> $stable(out_cmp_reg))
        else $error("held result overwritten");

    // profile phase only moves while a tick is being worked
    a_phase_idle_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !seq_busy_reg |=> $stable(phase_reg))
        else $error("phase changed with no tick in progress");

    // PWM is switched on only on entry to ramp up
    a_pwm_on_in_up: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(running_reg) |-> (phase_reg == PH_UP))
        else $error("PWM enabled outside ramp up");

endmodule

`default_nettype wire
